@@ design/hsv_histogram_normalizer_core_macros.svh @@
// Assertion macros for the HSV histogram normalizer.
`ifndef HSV_HISTOGRAM_NORMALIZER_CORE_MACROS_SVH
`define HSV_HISTOGRAM_NORMALIZER_CORE_MACROS_SVH

// Same-cycle implication, checked on i_clk outside of reset.
`define HSVHN_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hsvhn: same-cycle check failed");

// Next-cycle implication, checked on i_clk outside of reset.
`define HSVHN_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hsvhn: next-cycle check failed");

`endif

@@ design/hsvhn_pkg.sv @@
// Types and fixed constants of the HSV histogram normalizer.
package hsvhn_pkg;

    localparam int CH_W      = 8;    // width of one pixel channel
    localparam int PCT_W     = 7;    // min_percent width
    localparam int SCALE_W   = 8;    // output_scale width
    localparam int VAL_W     = 16;   // 8.8 bin value width
    localparam int FRAC_W    = 8;    // fraction bits of bin value
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 8;
    localparam int PCT_FULL  = 100;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PERCENT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_SCALE = 1'b1;

    localparam logic [PCT_W-1:0]   MIN_PERCENT_RST  = 7'd1;
    localparam logic [SCALE_W-1:0] OUTPUT_SCALE_RST = 8'd255;

    typedef enum logic [3:0] {
        ST_CLEAR,     // post-reset sweep zeroing the count memory
        ST_RUN,       // counting pixels
        ST_THRESH,    // latch keep threshold, clear pixel total
        ST_SUM,       // read pass accumulating kept counts
        ST_SUM_WAIT,  // drain of the sum pipeline
        ST_EM_RD,     // read one bin
        ST_EM_LD,     // bin count arrives, scale multiply, zero the entry
        ST_EM_PRE,    // load divider
        ST_EM_DIV,    // one quotient bit per cycle
        ST_EM_WAIT    // result word waiting for the sink
    } t_state;

endpackage

@@ design/hsvhn_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
module hsvhn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ design/hsv_histogram_normalizer_core.sv @@
// Top level of the HSV histogram normalizer: bin counting, threshold and L1 normalization.

// Pixels enter at one word per cycle while the core is counting; each one bumps its joint
// bin in the count memory through a one-deep read-modify-write pipeline with forwarding,
// so back-to-back hits on the same bin are counted correctly. The word carrying tlast stops
// intake and starts the frame burst: a threshold state latches the threshold, a sum pass
// runs over the single read port, then per kept bin one read, one multiply, one load and
// the bit-serial divider producing the VAL_W (16) bit quotient before the result word is
// offered; a bin that is not kept skips the divider. The counts are zeroed as they are
// read out, and intake resumes after the last bin is taken. After reset a clearing pass
// over all NBINS entries zeroes the count memory while no pixel is accepted. The
// configuration port is always ready and should be written only while no frame is open.
`include "hsv_histogram_normalizer_core_macros.svh"

module hsv_histogram_normalizer_core #(
    parameter int BINS_PER_CHANNEL = 4,
    parameter int COUNT_WIDTH      = 22
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration write channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [hsvhn_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [hsvhn_pkg::CFG_DAT_W-1:0]       i_cfg_data,
    // pixel stream
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // [7:0] hue, [15:8] saturation, [23:16] brightness
    input  logic [3*hsvhn_pkg::CH_W-1:0]          i_s_axis_tdata,
    input  logic                                  i_s_axis_tlast,   // frame_end
    // bin stream
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // bin_index from bit 0, then bin_value (16 bits), zero padded to bytes
    output logic [((($clog2(BINS_PER_CHANNEL**3) + hsvhn_pkg::VAL_W) + 7) / 8) * 8 - 1:0]
                                                  o_m_axis_tdata,
    output logic                                  o_m_axis_tlast    // last_bin
);

    localparam int NBINS = BINS_PER_CHANNEL * BINS_PER_CHANNEL * BINS_PER_CHANNEL;
    localparam int IDX_W = $clog2(NBINS);
    localparam int QW    = $clog2(BINS_PER_CHANNEL);
    localparam int MW    = hsvhn_pkg::CH_W + $clog2(BINS_PER_CHANNEL + 1);
    localparam int CW    = COUNT_WIDTH;
    localparam int PW    = CW + hsvhn_pkg::PCT_W;       // count * 100, percent * total
    localparam int NW    = CW + hsvhn_pkg::SCALE_W;     // count * scale
    localparam int SW    = CW + IDX_W;                  // sum of kept counts
    localparam int VW    = hsvhn_pkg::VAL_W;
    localparam int FW    = hsvhn_pkg::FRAC_W;
    localparam int STW   = $clog2(VW);
    localparam int OUT_W = ((IDX_W + VW + 7) / 8) * 8;
    localparam logic [IDX_W-1:0] LAST_BIN  = IDX_W'(NBINS - 1);
    localparam logic [STW-1:0]   LAST_STEP = STW'(VW - 1);

    function automatic logic [QW-1:0] quant(input logic [hsvhn_pkg::CH_W-1:0] v);
        logic [MW-1:0] p;
        p = MW'(v) * MW'(BINS_PER_CHANNEL);
        return QW'(p >> hsvhn_pkg::CH_W);
    endfunction

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] c);
        return (c == {CW{1'b1}}) ? c : c + CW'(1);
    endfunction

    hsvhn_pkg::t_state r_state, n_state;

    logic [hsvhn_pkg::PCT_W-1:0]   r_min_percent;
    logic [hsvhn_pkg::SCALE_W-1:0] r_scale;
    logic [IDX_W-1:0]              r_ptr;
    logic [CW-1:0]                 r_total;

    // pixel pipeline
    logic             r_p1_valid;
    logic [IDX_W-1:0] r_p1_addr;
    logic             r_wb_valid;
    logic [IDX_W-1:0] r_wb_addr;
    logic [CW-1:0]    r_wb_data;

    // frame burst datapath
    logic [PW-1:0]    r_threshold;
    logic [SW-1:0]    r_sum;
    logic             r_sum_rd;
    logic             r_k_vld;
    logic [CW-1:0]    r_k_val;
    logic             r_kept;
    logic [NW-1:0]    r_num;
    logic [SW-1:0]    r_rem;
    logic [VW-1:0]    r_dlo;
    logic [VW-1:0]    r_q;
    logic [STW-1:0]   r_step;

    // output register
    logic             r_out_valid;
    logic [IDX_W-1:0] r_out_idx;
    logic [VW-1:0]    r_out_val;
    logic             r_out_last;

    // memory port control
    logic             ram_rd_en;
    logic [IDX_W-1:0] ram_rd_addr;
    logic             ram_wr_en;
    logic [IDX_W-1:0] ram_wr_addr;
    logic [CW-1:0]    ram_wr_data;
    logic [CW-1:0]    ram_rd_data;

    logic             in_acc;
    logic             out_acc;
    logic             cfg_acc;
    logic [IDX_W-1:0] pix_idx;
    logic [CW-1:0]    pix_old;
    logic [CW-1:0]    pix_new;
    logic             kept_now;
    logic [SW:0]      div_t;
    logic             div_ge;
    logic [SW-1:0]    div_rem;
    logic [VW-1:0]    div_q;
    logic             ptr_inc;
    logic             ptr_clr;
    logic             sum_issue;
    logic             out_load;
    logic [VW-1:0]    out_load_val;

    assign o_cfg_ready     = 1'b1;
    assign cfg_acc         = i_cfg_valid && o_cfg_ready;
    assign o_s_axis_tready = (r_state == hsvhn_pkg::ST_RUN);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign out_acc         = r_out_valid && i_m_axis_tready;
    assign o_m_axis_tdata  = OUT_W'({r_out_val, r_out_idx});
    assign o_m_axis_tlast  = r_out_last;

    assign pix_idx = IDX_W'((IDX_W'(quant(i_s_axis_tdata[7:0])) * IDX_W'(BINS_PER_CHANNEL)
                     + IDX_W'(quant(i_s_axis_tdata[15:8]))) * IDX_W'(BINS_PER_CHANNEL)
                     + IDX_W'(quant(i_s_axis_tdata[23:16])));

    // forward the write of the previous cycle, which the memory read did not see
    assign pix_old = (r_wb_valid && (r_wb_addr == r_p1_addr)) ? r_wb_data : ram_rd_data;
    assign pix_new = sat_inc(pix_old);

    assign kept_now = (PW'(ram_rd_data) * PW'(hsvhn_pkg::PCT_FULL)) > r_threshold;

    // restoring divider step
    assign div_t   = {r_rem, r_dlo[VW-1]};
    assign div_ge  = div_t >= {1'b0, r_sum};
    assign div_rem = div_ge ? SW'(div_t - {1'b0, r_sum}) : SW'(div_t);
    assign div_q   = {r_q[VW-2:0], div_ge};

    hsvhn_ram #(
        .WIDTH(CW),
        .DEPTH(NBINS)
    ) u_counts (
        .i_clk    (i_clk),
        .i_wr_en  (ram_wr_en),
        .i_wr_addr(ram_wr_addr),
        .i_wr_data(ram_wr_data),
        .i_rd_en  (ram_rd_en),
        .i_rd_addr(ram_rd_addr),
        .o_rd_data(ram_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hsvhn_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        ram_rd_en    = 1'b0;
        ram_rd_addr  = r_ptr;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = r_ptr;
        ram_wr_data  = '0;
        ptr_inc      = 1'b0;
        ptr_clr      = 1'b0;
        sum_issue    = 1'b0;
        out_load     = 1'b0;
        out_load_val = '0;
        if (r_p1_valid) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = r_p1_addr;
            ram_wr_data = pix_new;
        end
        case (r_state)
            hsvhn_pkg::ST_CLEAR: begin
                ram_wr_en = 1'b1;
                if (r_ptr == LAST_BIN) begin
                    ptr_clr = 1'b1;
                    n_state = hsvhn_pkg::ST_RUN;
                end else begin
                    ptr_inc = 1'b1;
                end
            end
            hsvhn_pkg::ST_RUN: begin
                if (in_acc) begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = pix_idx;
                    if (i_s_axis_tlast) begin
                        n_state = hsvhn_pkg::ST_THRESH;
                    end
                end
            end
            hsvhn_pkg::ST_THRESH: begin
                n_state = hsvhn_pkg::ST_SUM;
            end
            hsvhn_pkg::ST_SUM: begin
                ram_rd_en = 1'b1;
                sum_issue = 1'b1;
                if (r_ptr == LAST_BIN) begin
                    ptr_clr = 1'b1;
                    n_state = hsvhn_pkg::ST_SUM_WAIT;
                end else begin
                    ptr_inc = 1'b1;
                end
            end
            hsvhn_pkg::ST_SUM_WAIT: begin
                if (!r_sum_rd && !r_k_vld) begin
                    n_state = hsvhn_pkg::ST_EM_RD;
                end
            end
            hsvhn_pkg::ST_EM_RD: begin
                ram_rd_en = 1'b1;
                n_state   = hsvhn_pkg::ST_EM_LD;
            end
            hsvhn_pkg::ST_EM_LD: begin
                // entry is read out, zero it for the next frame
                ram_wr_en = 1'b1;
                n_state   = hsvhn_pkg::ST_EM_PRE;
            end
            hsvhn_pkg::ST_EM_PRE: begin
                if (r_kept) begin
                    n_state = hsvhn_pkg::ST_EM_DIV;
                end else begin
                    out_load = 1'b1;
                    n_state  = hsvhn_pkg::ST_EM_WAIT;
                end
            end
            hsvhn_pkg::ST_EM_DIV: begin
                if (r_step == LAST_STEP) begin
                    out_load     = 1'b1;
                    out_load_val = div_q;
                    n_state      = hsvhn_pkg::ST_EM_WAIT;
                end
            end
            hsvhn_pkg::ST_EM_WAIT: begin
                if (out_acc) begin
                    if (r_ptr == LAST_BIN) begin
                        ptr_clr = 1'b1;
                        n_state = hsvhn_pkg::ST_RUN;
                    end else begin
                        ptr_inc = 1'b1;
                        n_state = hsvhn_pkg::ST_EM_RD;
                    end
                end
            end
            default: begin
                n_state = hsvhn_pkg::ST_CLEAR;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_percent <= hsvhn_pkg::MIN_PERCENT_RST;
            r_scale       <= hsvhn_pkg::OUTPUT_SCALE_RST;
            r_ptr         <= '0;
            r_total       <= '0;
            r_p1_valid    <= 1'b0;
            r_wb_valid    <= 1'b0;
            r_sum_rd      <= 1'b0;
            r_k_vld       <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (cfg_acc) begin
                case (i_cfg_index)
                    hsvhn_pkg::CFG_MIN_PERCENT:  r_min_percent <= i_cfg_data[hsvhn_pkg::PCT_W-1:0];
                    hsvhn_pkg::CFG_OUTPUT_SCALE: r_scale       <= i_cfg_data;
                    default: ;
                endcase
            end
            if (ptr_clr) begin
                r_ptr <= '0;
            end else if (ptr_inc) begin
                r_ptr <= r_ptr + IDX_W'(1);
            end
            if (r_state == hsvhn_pkg::ST_THRESH) begin
                r_total <= '0;
            end else if (in_acc) begin
                r_total <= sat_inc(r_total);
            end
            r_p1_valid <= in_acc;
            r_wb_valid <= r_p1_valid;
            r_sum_rd   <= sum_issue;
            r_k_vld    <= r_sum_rd;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_p1_addr <= pix_idx;
        end
        r_wb_addr <= r_p1_addr;
        r_wb_data <= pix_new;
        if (r_state == hsvhn_pkg::ST_THRESH) begin
            r_threshold <= PW'(r_min_percent) * PW'(r_total);
        end
        if (r_state == hsvhn_pkg::ST_THRESH) begin
            r_sum <= '0;
        end else if (r_k_vld) begin
            r_sum <= r_sum + SW'(r_k_val);
        end
        r_k_val <= kept_now ? ram_rd_data : '0;
        if (r_state == hsvhn_pkg::ST_EM_LD) begin
            r_kept <= kept_now;
            r_num  <= NW'(ram_rd_data) * NW'(r_scale);
        end
        if (r_state == hsvhn_pkg::ST_EM_PRE) begin
            // quotient fits VW bits, so the top of count*scale*256 starts below the sum
            r_rem  <= SW'(r_num >> FW);
            r_dlo  <= {r_num[FW-1:0], {(VW - FW){1'b0}}};
            r_q    <= '0;
            r_step <= '0;
        end else if (r_state == hsvhn_pkg::ST_EM_DIV) begin
            r_rem  <= div_rem;
            r_dlo  <= {r_dlo[VW-2:0], 1'b0};
            r_q    <= div_q;
            r_step <= r_step + STW'(1);
        end
        if (out_load) begin
            r_out_idx  <= r_ptr;
            r_out_val  <= out_load_val;
            r_out_last <= (r_ptr == LAST_BIN);
        end
    end

    `HSVHN_ASSERT_IMP(a_no_intake_during_emit, o_s_axis_tready, !o_m_axis_tvalid)
    `HSVHN_ASSERT_IMP(a_pixel_write_owns_port, r_p1_valid,
        (r_state == hsvhn_pkg::ST_RUN) || (r_state == hsvhn_pkg::ST_THRESH))
    `HSVHN_ASSERT_IMP(a_div_rem_below_sum, r_state == hsvhn_pkg::ST_EM_DIV, r_rem < r_sum)
    `HSVHN_ASSERT_NXT(a_resume_after_last, out_acc && r_out_last, o_s_axis_tready)

endmodule
